// ----- design/efd_pkg.sv -----
`default_nettype none
package efd_pkg;

	localparam logic [7:0] MARK_START  = 8'h7B;
	localparam logic [7:0] MARK_END    = 8'h7D;
	localparam logic [7:0] MARK_ESC    = 8'h5C;
	localparam int unsigned MIN_CONTENT = 4;
	localparam int unsigned POS_W       = 3;
	localparam int unsigned USER_W      = 5;

	typedef enum logic [2:0] {
		ROLE_COUNTER = 3'd0,
		ROLE_GROUP   = 3'd1,
		ROLE_COMMAND = 3'd2,
		ROLE_DATA    = 3'd3,
		ROLE_CRC     = 3'd4
	} role_t;

	typedef struct packed {
		logic [7:0] out_byte;
		role_t      role;
		logic       last_of_frame;
		logic       sequence_error;
		logic       frame_error;
	} result_t;

endpackage
`default_nettype wire

// ----- design/efd_in_stage.sv -----
`default_nettype none
module efd_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

endmodule
`default_nettype wire

// ----- design/efd_decoder.sv -----
`default_nettype none
module efd_decoder (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        byte_s1,
	input  wire logic              take,
	output logic                   emit,
	output efd_pkg::result_t       result
);

	logic                       in_frame_q, in_frame_d;
	logic                       esc_q, esc_d;
	logic [efd_pkg::POS_W-1:0]  pos_q, pos_d;
	logic [7:0]                 held_q, held_d;
	logic [7:0]                 fcnt_q, fcnt_d;
	logic [7:0]                 lcnt_q, lcnt_d;
	logic                       seen_q, seen_d;
	logic                       content;
	logic                       full;
	logic [7:0]                 expect_cnt;

	assign full       = (pos_q >= efd_pkg::POS_W'(efd_pkg::MIN_CONTENT));
	assign expect_cnt = lcnt_q + 8'd1;

	always_comb begin
		in_frame_d = in_frame_q;
		esc_d      = esc_q;
		pos_d      = pos_q;
		held_d     = held_q;
		fcnt_d     = fcnt_q;
		lcnt_d     = lcnt_q;
		seen_d     = seen_q;
		content    = 1'b0;
		emit       = 1'b0;
		result     = '{out_byte: held_q, role: efd_pkg::ROLE_CRC, last_of_frame: 1'b0,
			sequence_error: 1'b0, frame_error: 1'b0};

		if (esc_q) begin
			esc_d   = 1'b0;
			content = in_frame_q;
		end else if (byte_s1 == efd_pkg::MARK_ESC) begin
			esc_d = 1'b1;
		end else if (byte_s1 == efd_pkg::MARK_START) begin
			in_frame_d = 1'b1;
			pos_d      = '0;
		end else if (!in_frame_q) begin
			in_frame_d = 1'b0;
		end else if (byte_s1 == efd_pkg::MARK_END) begin
			in_frame_d           = 1'b0;
			pos_d                = '0;
			emit                 = 1'b1;
			result.last_of_frame = 1'b1;
			if (!full) begin
				result.out_byte    = 8'd0;
				result.frame_error = 1'b1;
			end else begin
				result.sequence_error = seen_q && (expect_cnt != fcnt_q);
				lcnt_d                = fcnt_q;
				seen_d                = 1'b1;
			end
		end else begin
			content = 1'b1;
		end

		if (content) begin
			held_d = byte_s1;
			if (!full) begin
				pos_d = pos_q + efd_pkg::POS_W'(1);
			end
			if (pos_q == '0) begin
				fcnt_d = byte_s1;
			end else begin
				emit = 1'b1;
				case (pos_q)
					efd_pkg::POS_W'(1): result.role = efd_pkg::ROLE_COUNTER;
					efd_pkg::POS_W'(2): result.role = efd_pkg::ROLE_GROUP;
					efd_pkg::POS_W'(3): result.role = efd_pkg::ROLE_COMMAND;
					default:            result.role = efd_pkg::ROLE_DATA;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			pos_q      <= '0;
			held_q     <= 8'd0;
			fcnt_q     <= 8'd0;
			lcnt_q     <= 8'd0;
			seen_q     <= 1'b0;
		end else if (take) begin
			in_frame_q <= in_frame_d;
			esc_q      <= esc_d;
			pos_q      <= pos_d;
			held_q     <= held_d;
			fcnt_q     <= fcnt_d;
			lcnt_q     <= lcnt_d;
			seen_q     <= seen_d;
		end
	end

endmodule
`default_nettype wire

// ----- design/efd_out_stage.sv -----
`default_nettype none
module efd_out_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire efd_pkg::result_t in_result,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output efd_pkg::result_t      out_result
);

	assign in_ready = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_result <= in_result;
		end
	end

endmodule
`default_nettype wire

// ----- design/escaped_frame_decoder_seq_check.sv -----
// Byte-stuffed frame decoder with packet counter check. Takes one received byte per
// cycle and sustains one byte per clock while the master side is ready; a word goes
// through the input register and the decode state into the result register before its
// result is presented on the master side. Start 0x7B opens or restarts a frame, end
// 0x7D closes it, escape 0x5C makes the next byte literal. Content bytes come out one
// word late, tagged counter, group, command or data in tuser; the last one is emitted
// as crc with tlast on the end marker, with the sequence and short-frame flags, and a
// short frame's crc word carries zero instead. Backpressure on the master side stalls
// the input only when a stage holding a result cannot drain.
`default_nettype none
module escaped_frame_decoder_seq_check_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [7:0]                  s_axis_tdata,  // rx_byte
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [7:0]                       m_axis_tdata,  // out_byte
	output logic                             m_axis_tlast,  // last_of_frame
	output logic [efd_pkg::USER_W-1:0]       m_axis_tuser   // role[2:0], sequence_error, frame_error
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	logic             emit;
	logic             res_ready;
	efd_pkg::result_t result;
	efd_pkg::result_t out_result;

	assign advance = valid_s1 && (!emit || res_ready);

	efd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	efd_decoder u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_s1 (byte_s1),
		.take    (advance),
		.emit    (emit),
		.result  (result)
	);

	efd_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (valid_s1 && emit),
		.in_ready   (res_ready),
		.in_result  (result),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (out_result)
	);

	assign m_axis_tdata = out_result.out_byte;
	assign m_axis_tlast = out_result.last_of_frame;
	assign m_axis_tuser = {out_result.frame_error, out_result.sequence_error, out_result.role};

endmodule
`default_nettype wire

// ----- design/efd_checker.sv -----
`default_nettype none
module efd_checker (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [7:0]            m_axis_tdata,
	input wire logic                  m_axis_tlast,
	input wire logic [efd_pkg::USER_W-1:0] m_axis_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled word changed");

	a_flags_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[4:3] == 2'b00)
		else $error("error flag outside frame end");

	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[4] |-> m_axis_tdata == 8'd0 && !m_axis_tuser[3])
		else $error("short frame word malformed");

	a_crc_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tlast == (m_axis_tuser[2:0] == efd_pkg::ROLE_CRC))
		else $error("crc role and tlast disagree");

endmodule

bind escaped_frame_decoder_seq_check_core efd_checker u_efd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ----- test/escaped_frame_decoder_seq_check_core_checker.sv -----
`timescale 1ns / 100ps
module escaped_frame_decoder_seq_check_core_checker (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	input  wire logic                  s_axis_tready,
	input  wire logic [7:0]            s_axis_tdata,  // rx_byte
	input  wire logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	input  wire logic [7:0]            m_axis_tdata,  // out_byte
	input  wire logic                  m_axis_tlast,  // last_of_frame
	input  wire logic [efd_pkg::USER_W-1:0] m_axis_tuser, // role[2:0], sequence_error, frame_error
	output int                         mismatches,
	output int                         awaiting
);
	import efd_pkg::*;

	logic       in_frame;
	logic       esc_pending;
	logic [2:0] content_pos;
	logic [7:0] held;
	logic [7:0] frame_cnt;
	logic [7:0] last_cnt;
	logic       seen_good;
	int         faults;

	result_t    decoded_words[$];

	assign mismatches = faults;

	task automatic take_content(input logic [7:0] b, output bit emit, output result_t r);
		r = '0;
		emit = 1'b0;
		if (content_pos == 3'd0) begin
			frame_cnt = b;
		end else begin
			emit = 1'b1;
			r.out_byte = held;
			case (content_pos)
				3'd1: r.role = ROLE_COUNTER;
				3'd2: r.role = ROLE_GROUP;
				3'd3: r.role = ROLE_COMMAND;
				default: r.role = ROLE_DATA;
			endcase
		end
		held = b;
		if (content_pos < MIN_CONTENT)
			content_pos = content_pos + 3'd1;
	endtask

	task automatic decode_byte(input logic [7:0] b);
		bit         emit;
		result_t    r;
		logic [7:0] want;
		emit = 1'b0;
		r = '0;
		if (esc_pending) begin
			esc_pending = 1'b0;
			if (in_frame)
				take_content(b, emit, r);
		end else if (b == MARK_ESC) begin
			esc_pending = 1'b1;
		end else if (b == MARK_START) begin
			in_frame = 1'b1;
			content_pos = 3'd0;
		end else if (in_frame) begin
			if (b == MARK_END) begin
				in_frame = 1'b0;
				emit = 1'b1;
				r.role = ROLE_CRC;
				r.last_of_frame = 1'b1;
				if (content_pos < MIN_CONTENT) begin
					r.frame_error = 1'b1;
				end else begin
					// counter wraps modulo 256
					want = last_cnt + 8'd1;
					r.sequence_error = (want != frame_cnt) && seen_good;
					r.out_byte = held;
					last_cnt = frame_cnt;
					seen_good = 1'b1;
				end
				content_pos = 3'd0;
			end else begin
				take_content(b, emit, r);
			end
		end
		if (emit)
			decoded_words = {decoded_words, r};
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t r;
		if (!arst_n) begin
			in_frame = 1'b0;
			esc_pending = 1'b0;
			content_pos = 3'd0;
			held = 8'd0;
			frame_cnt = 8'd0;
			last_cnt = 8'd0;
			seen_good = 1'b0;
			faults = 0;
			decoded_words.delete();
			awaiting <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (decoded_words.size() == 0) begin
					$error("result word with nothing expected: byte %0h user %0h last %0b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					faults = faults + 1;
				end else begin
					r = decoded_words.pop_front();
					if (m_axis_tdata !== r.out_byte) begin
						$error("out_byte: expected %0h, got %0h", r.out_byte, m_axis_tdata);
						faults = faults + 1;
					end
					if (m_axis_tuser[2:0] !== r.role) begin
						$error("role: expected %0d, got %0d", r.role, m_axis_tuser[2:0]);
						faults = faults + 1;
					end
					if (m_axis_tlast !== r.last_of_frame) begin
						$error("last_of_frame: expected %0b, got %0b",
							r.last_of_frame, m_axis_tlast);
						faults = faults + 1;
					end
					if (m_axis_tuser[3] !== r.sequence_error) begin
						$error("sequence_error: expected %0b, got %0b",
							r.sequence_error, m_axis_tuser[3]);
						faults = faults + 1;
					end
					if (m_axis_tuser[4] !== r.frame_error) begin
						$error("frame_error: expected %0b, got %0b",
							r.frame_error, m_axis_tuser[4]);
						faults = faults + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				decode_byte(s_axis_tdata);
			awaiting <= decoded_words.size();
		end
	end

endmodule

// ----- test/escaped_frame_decoder_seq_check_core_test.sv -----
`timescale 1ns / 100ps
module escaped_frame_decoder_seq_check_core_test;
	import efd_pkg::*;

	localparam int TOTAL_ITEMS = 1450;
	localparam int N_PHASES    = 4;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata = 8'd0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [7:0]             m_axis_tdata;
	logic                   m_axis_tlast;
	logic [USER_W-1:0]      m_axis_tuser;

	int                     mismatches;
	int                     awaiting;
	int                     idle_pct = 0;
	int                     stall_pct = 0;
	logic [7:0]             next_count = 8'd0;

	int idle_tab[N_PHASES]  = '{0, 63, 0, 16};
	int stall_tab[N_PHASES] = '{0, 0, 63, 16};

	always #1 clk = ~clk;

	escaped_frame_decoder_seq_check_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	escaped_frame_decoder_seq_check_core_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.awaiting      (awaiting)
	);

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= stall_pct);

	task automatic push_word(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		do @(posedge clk); while (awaiting != 0);
	endtask

	function automatic logic [7:0] pick_byte(input int marker_pct);
		logic [7:0] b;
		b = 8'($urandom);
		if ($urandom_range(99) < marker_pct) begin
			case ($urandom_range(2))
				0: b = MARK_START;
				1: b = MARK_END;
				default: b = MARK_ESC;
			endcase
		end
		return b;
	endfunction

	task automatic send_frame(output int pushed);
		int         kind;
		int         len;
		logic [7:0] cnt;
		logic [7:0] b;
		pushed = 0;
		kind = $urandom_range(99);
		// stray bytes between frames now and then
		if ($urandom_range(99) < 12) begin
			repeat ($urandom_range(1, 3)) begin
				push_word(pick_byte(40));
				pushed++;
			end
		end
		cnt = ($urandom_range(99) < 85) ? next_count : 8'($urandom);
		next_count = cnt + 8'd1;
		len = (kind < 8) ? $urandom_range(0, 3) : $urandom_range(4, 12);
		push_word(MARK_START);
		pushed++;
		for (int i = 0; i < len; i++) begin
			b = (i == 0) ? cnt : pick_byte(20);
			if ((b == MARK_START || b == MARK_END || b == MARK_ESC) &&
			    $urandom_range(99) < 96) begin
				push_word(MARK_ESC);
				pushed++;
			end
			push_word(b);
			pushed++;
		end
		// abandoned frames get restarted by the next start marker
		if (kind < 8 || kind >= 13) begin
			push_word(MARK_END);
			pushed++;
		end
	endtask

	initial begin
		logic [7:0] opening[];
		int         items;
		int         n;
		opening = '{
			MARK_END, MARK_ESC, MARK_START,
			MARK_START, 8'h01, MARK_START, 8'hFF, MARK_ESC, MARK_START, MARK_ESC, MARK_END,
			MARK_ESC, MARK_ESC, 8'h00, MARK_END,
			MARK_START, 8'h00, 8'h11, 8'h22, 8'h33, MARK_END,
			MARK_START, MARK_END,
			MARK_START, 8'h09, 8'hAA, 8'h55, 8'h80, MARK_END
		};
		items = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (opening[i])
			push_word(opening[i]);
		s_axis_tvalid <= 1'b0;
		drain();
		next_count = 8'h0A;
		for (int p = 0; p < N_PHASES; p++) begin
			idle_pct = idle_tab[p];
			stall_pct = stall_tab[p];
			while (items < TOTAL_ITEMS * (p + 1) / N_PHASES) begin
				send_frame(n);
				items += n;
			end
			// hold off until every result of the phase has come out
			s_axis_tvalid <= 1'b0;
			drain();
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0 && awaiting == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#400000;
		$display("FAILURE");
		$finish;
	end

endmodule
